// ===== sv/bcc_pkg.sv =====
// shared types, constants and lookup tables for the button click classifier
package bcc_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int NOW_W   = 32;
  localparam int EV_W    = 2;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 8;
  localparam int MS_W    = 14;

  localparam logic [CFG_A_W-1:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_DC_LEVEL    = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_LP_LEVEL    = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_ACTIVE_HIGH = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_PAUSE       = 3'd4;

  localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EV_W-1:0] EV_SINGLE = 2'd1;
  localparam logic [EV_W-1:0] EV_DOUBLE = 2'd2;
  localparam logic [EV_W-1:0] EV_LONG   = 2'd3;

  typedef struct packed {
    logic [7:0] debounce_ms;
    logic [3:0] dc_window_sel;
    logic [2:0] lp_time_sel;
    logic       active_high;
    logic       pause_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    debounce_ms:   8'd20,
    dc_window_sel: 4'd1,
    lp_time_sel:   3'd0,
    active_high:   1'b0,
    pause_enable:  1'b0
  };

  function automatic logic [MS_W-1:0] dc_window_ms(input logic [3:0] level);
    logic [MS_W-1:0] ms;
    case (level)
      4'd0:    ms = 14'd100;
      4'd1:    ms = 14'd200;
      4'd2:    ms = 14'd300;
      4'd3:    ms = 14'd400;
      4'd4:    ms = 14'd500;
      4'd5:    ms = 14'd600;
      4'd6:    ms = 14'd700;
      4'd7:    ms = 14'd800;
      4'd8:    ms = 14'd900;
      default: ms = 14'd1000;
    endcase
    return ms;
  endfunction

  function automatic logic [MS_W-1:0] lp_time_ms(input logic [2:0] level);
    logic [MS_W-1:0] ms;
    case (level)
      3'd0:    ms = 14'd3000;
      3'd1:    ms = 14'd4000;
      3'd2:    ms = 14'd5000;
      3'd3:    ms = 14'd6000;
      3'd4:    ms = 14'd7000;
      3'd5:    ms = 14'd8000;
      3'd6:    ms = 14'd9000;
      default: ms = 14'd10000;
    endcase
    return ms;
  endfunction

endpackage

// ===== sv/button_click_classifier.sv =====
// top level: button click classifier with debounce front end and classifier back end
// path: an accepted scan waits in the queue, and its event is then loaded into the result register on out_tdata
// throughput: one scan per cycle while out_tready stays high, set by the two-entry queue and the result register
// the front end takes scans while a result waits; it stops only when the queue is full
// reset: synchronous active-low rst_n clears filter, click state, queue and result valid
// reset loads the register defaults: 20 ms debounce, 200 ms window, 3000 ms long press
module button_click_classifier #(
  parameter int TIME_WIDTH  = bcc_pkg::TIME_WIDTH_DEF,
  parameter int QUEUE_DEPTH = bcc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [39:0]                   in_tdata,    // pin_level, now_ms[31:0], zero pad
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,   // event_code[1:0], zero pad
  input  logic                          cfg_wr_en,
  input  logic [bcc_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [bcc_pkg::CFG_D_W-1:0]   cfg_wr_data
);

  localparam int QW = TIME_WIDTH + 1;

  bcc_pkg::cfg_t              cfg_r, cfg_nxt;
  logic                       cfg_clear;
  logic                       scan_en;
  logic                       level_nxt;
  logic [TIME_WIDTH-1:0]      now;
  logic                       q_full, q_pop, q_valid;
  logic [QW-1:0]              q_head;
  logic [bcc_pkg::EV_W-1:0]   ev;

  assign in_tready = !q_full;
  assign scan_en   = in_tvalid && in_tready;
  assign now       = TIME_WIDTH'(in_tdata[bcc_pkg::NOW_W:1]);

  always_comb begin
    cfg_nxt   = cfg_r;
    cfg_clear = 1'b0;
    if (cfg_wr_en) begin
      cfg_clear = 1'b1;
      case (cfg_addr)
        bcc_pkg::REG_DEBOUNCE:    cfg_nxt.debounce_ms   = cfg_wr_data;
        bcc_pkg::REG_DC_LEVEL:    cfg_nxt.dc_window_sel = cfg_wr_data[3:0];
        bcc_pkg::REG_LP_LEVEL:    cfg_nxt.lp_time_sel   = cfg_wr_data[2:0];
        bcc_pkg::REG_ACTIVE_HIGH: cfg_nxt.active_high   = cfg_wr_data[0];
        bcc_pkg::REG_PAUSE:       cfg_nxt.pause_enable  = cfg_wr_data[0];
        default:                  cfg_clear             = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= bcc_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bcc_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .scan_en   (scan_en),
    .pin_level (in_tdata[0]),
    .now       (now),
    .level_nxt (level_nxt)
  );

  bcc_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (scan_en),
    .push_data  ({now, level_nxt}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  bcc_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .clear      (cfg_clear),
    .head_valid (q_valid),
    .head_level (q_head[0]),
    .head_now   (q_head[QW-1:1]),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_event  (ev),
    .out_ready  (out_tready)
  );

  assign out_tdata = {6'd0, ev};

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    scan_en |-> !q_full)
    else $error("scan pushed into a full queue");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_pop_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_tvalid)
    else $error("popped scan produced no result");

  a_reset_clears_valid: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
`endif

endmodule

// ===== sv/bcc_front.sv =====
// front end: polarity and debounce filter, one scan per cycle
module bcc_front #(
  parameter int TIME_WIDTH = bcc_pkg::TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bcc_pkg::cfg_t         cfg,
  input  logic                  scan_en,
  input  logic                  pin_level,
  input  logic [TIME_WIDTH-1:0] now,
  output logic                  level_nxt
);

  logic                  filt_r, filt_nxt;
  logic [TIME_WIDTH-1:0] settle_r, settle_nxt;
  logic [1:0]            last_raw_r, last_raw_nxt;
  logic                  raw;
  logic [TIME_WIDTH-1:0] settled_for;

  always_comb begin
    raw          = cfg.active_high ? pin_level : ~pin_level;
    filt_nxt     = filt_r;
    settle_nxt   = settle_r;
    last_raw_nxt = last_raw_r;
    if (!cfg.pause_enable) begin
      if (raw != filt_r) begin
        if ({1'b0, raw} != last_raw_r) begin
          settle_nxt   = now;
          last_raw_nxt = {1'b0, raw};
        end
      end else begin
        last_raw_nxt = {1'b0, raw};
      end
    end
    settled_for = now - settle_nxt;
    if (!cfg.pause_enable && raw != filt_r &&
        settled_for >= TIME_WIDTH'(cfg.debounce_ms)) begin
      filt_nxt = raw;
    end
  end

  assign level_nxt = filt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r     <= 1'b0;
      settle_r   <= '0;
      last_raw_r <= 2'd3;
    end else if (scan_en) begin
      filt_r     <= filt_nxt;
      settle_r   <= settle_nxt;
      last_raw_r <= last_raw_nxt;
    end
  end

endmodule

// ===== sv/bcc_queue.sv =====
// short register queue between front and back end
module bcc_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = bcc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/bcc_back.sv =====
// back end: press/release tracking, click classification and result register
module bcc_back #(
  parameter int TIME_WIDTH = bcc_pkg::TIME_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bcc_pkg::cfg_t                cfg,
  input  logic                         clear,
  input  logic                         head_valid,
  input  logic                         head_level,
  input  logic [TIME_WIDTH-1:0]        head_now,
  output logic                         pop,
  output logic                         out_valid,
  output logic [bcc_pkg::EV_W-1:0]     out_event,
  input  logic                         out_ready
);

  logic                      held_r, held_nxt;
  logic [TIME_WIDTH-1:0]     press_r, press_nxt;
  logic [TIME_WIDTH-1:0]     release_r, release_nxt;
  logic [1:0]                pend_r, pend_nxt;
  logic                      lf_r, lf_nxt;
  logic                      ov_r, ov_nxt;
  logic [bcc_pkg::EV_W-1:0]  ev_r, ev_nxt;
  logic [TIME_WIDTH-1:0]     press_age, release_age, now_age;
  logic [TIME_WIDTH-1:0]     deb, dcw, lpt;

  assign pop       = head_valid && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_event = ev_r;

  always_comb begin
    deb         = TIME_WIDTH'(cfg.debounce_ms);
    dcw         = TIME_WIDTH'(bcc_pkg::dc_window_ms(cfg.dc_window_sel));
    lpt         = TIME_WIDTH'(bcc_pkg::lp_time_ms(cfg.lp_time_sel));
    held_nxt    = held_r;
    press_nxt   = press_r;
    release_nxt = release_r;
    pend_nxt    = pend_r;
    lf_nxt      = lf_r;
    ev_nxt      = bcc_pkg::EV_NONE;
    press_age   = head_now - press_r;

    if (!cfg.pause_enable) begin
      // press edge
      if (head_level && !held_r) begin
        held_nxt  = 1'b1;
        press_nxt = head_now;
        lf_nxt    = 1'b0;
      end
      // release edge
      if (!head_level && held_r) begin
        held_nxt = 1'b0;
        if (!lf_r && press_age > deb) begin
          if (pend_r != 2'd3) begin
            pend_nxt = pend_r + 2'd1;
          end
          release_nxt = head_now;
        end
      end
    end

    now_age     = head_now - press_nxt;
    release_age = head_now - release_nxt;

    if (!cfg.pause_enable) begin
      if (held_nxt && !lf_nxt && now_age >= lpt) begin
        lf_nxt   = 1'b1;
        pend_nxt = 2'd0;
        ev_nxt   = bcc_pkg::EV_LONG;
      end else if (pend_nxt != 2'd0 && !held_nxt) begin
        if (pend_nxt == 2'd2) begin
          pend_nxt = 2'd0;
          ev_nxt   = bcc_pkg::EV_DOUBLE;
        end else if (pend_nxt == 2'd1 && release_age >= dcw) begin
          pend_nxt = 2'd0;
          ev_nxt   = bcc_pkg::EV_SINGLE;
        end
      end
    end

    if (pop) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= 1'b0;
      press_r   <= '0;
      release_r <= '0;
      pend_r    <= 2'd0;
      lf_r      <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (clear) begin
        held_r    <= 1'b0;
        press_r   <= '0;
        release_r <= '0;
        pend_r    <= 2'd0;
        lf_r      <= 1'b0;
      end else if (pop) begin
        held_r    <= held_nxt;
        press_r   <= press_nxt;
        release_r <= release_nxt;
        pend_r    <= pend_nxt;
        lf_r      <= lf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ev_r <= ev_nxt;
    end
  end

endmodule

// ===== tb/tb_button_click_classifier.sv =====
// self-checking testbench for the button click classifier: random button gestures against a predictor
`timescale 1ns / 100ps

module tb_button_click_classifier;

  typedef logic [bcc_pkg::CFG_A_W-1:0] cfg_addr_t;
  typedef logic [bcc_pkg::CFG_D_W-1:0] cfg_data_t;

  localparam int ITEM_GOAL = 1800;
  localparam int MAX_IDLE  = 11;
  localparam cfg_addr_t ADDR_MAX = '1;

  typedef struct packed {
    logic        pin;
    logic [31:0] now_ms;
  } scan_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;   // pin_level, now_ms[31:0], zero pad
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;        // event_code[1:0], zero pad
  logic cfg_wr_en = 1'b0;
  cfg_addr_t cfg_addr = '0;
  cfg_data_t cfg_wr_data = '0;

  button_click_classifier dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bcc_pkg::cfg_t cls_cfg;
  logic        flt_level;
  logic [31:0] settle_t0;
  logic [1:0]  prev_raw;
  logic        is_down;
  logic [31:0] down_ms;
  logic [31:0] up_ms;
  logic [1:0]  click_cnt;
  logic        long_sent;

  scan_t       pending_scans[$];
  logic [1:0]  want_events[$];
  logic [31:0] stamp_ms;
  int          phase_items;
  int          total_items;
  int          fail_count;
  int          gap_left;
  int          stall_left;
  logic        snd_idle_on;
  logic        rcv_idle_on;
  logic [1:0]  want;

  function automatic logic [31:0] window_ms(input bcc_pkg::cfg_t c);
    return (c.dc_window_sel > 4'd9) ? 32'd1000 : 32'd100 * (c.dc_window_sel + 32'd1);
  endfunction

  function automatic logic [31:0] hold_ms(input bcc_pkg::cfg_t c);
    return 32'd1000 * (c.lp_time_sel + 32'd3);
  endfunction

  function automatic logic [31:0] age(input logic [31:0] t, input logic [31:0] since);
    return t - since;
  endfunction

  function automatic void clear_clicks();
    is_down = 1'b0;
    down_ms = '0;
    up_ms = '0;
    click_cnt = '0;
    long_sent = 1'b0;
  endfunction

  function automatic logic [1:0] classify_scan(input logic pin, input logic [31:0] t);
    logic raw;
    raw = cls_cfg.active_high ? pin : ~pin;
    if (cls_cfg.pause_enable) return bcc_pkg::EV_NONE;
    if (raw != flt_level) begin
      if ({1'b0, raw} != prev_raw) begin
        settle_t0 = t;
        prev_raw = {1'b0, raw};
      end
      if (age(t, settle_t0) >= {24'd0, cls_cfg.debounce_ms}) flt_level = raw;
    end else begin
      prev_raw = {1'b0, raw};
    end
    if (flt_level && !is_down) begin
      is_down = 1'b1;
      down_ms = t;
      long_sent = 1'b0;
    end
    if (!flt_level && is_down) begin
      is_down = 1'b0;
      if (!long_sent && age(t, down_ms) > {24'd0, cls_cfg.debounce_ms}) begin
        if (click_cnt != 2'd3) click_cnt = click_cnt + 2'd1;
        up_ms = t;
      end
    end
    if (is_down && !long_sent && age(t, down_ms) >= hold_ms(cls_cfg)) begin
      long_sent = 1'b1;
      click_cnt = '0;
      return bcc_pkg::EV_LONG;
    end
    if (!is_down && click_cnt == 2'd2) begin
      click_cnt = '0;
      return bcc_pkg::EV_DOUBLE;
    end
    if (!is_down && click_cnt == 2'd1 && age(t, up_ms) >= window_ms(cls_cfg)) begin
      click_cnt = '0;
      return bcc_pkg::EV_SINGLE;
    end
    return bcc_pkg::EV_NONE;
  endfunction

  // scan driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        want_events.push_back(classify_scan(in_tdata[0], in_tdata[32:1]));
        pending_scans.delete(0);
        gap_left = snd_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_scans.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {7'd0, pending_scans[0].now_ms, pending_scans[0].pin};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // event monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (want_events.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 20)
            $display("%0t: event with none expected, expected none got %0d", $time,
                     out_tdata[1:0]);
        end else begin
          want = want_events.pop_front();
          if (out_tdata[1:0] !== want) begin
            fail_count = fail_count + 1;
            if (fail_count <= 20)
              $display("%0t: event mismatch, expected %0d got %0d", $time, want,
                       out_tdata[1:0]);
          end
        end
        stall_left = rcv_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic add_scan(input logic pin, input logic [31:0] t);
    scan_t s;
    s.pin = pin;
    s.now_ms = t;
    pending_scans.push_back(s);
    phase_items = phase_items + 1;
    if (!cls_cfg.pause_enable) total_items = total_items + 1;
  endtask

  // one stable level for dur ms, optionally preceded by contact bounce
  task automatic hold_level(input logic act, input int dur, input logic bounce);
    logic pin;
    int n;
    logic [31:0] t0;
    pin = cls_cfg.active_high ? act : ~act;
    if (bounce) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        add_scan((i % 2 == 0) ? ~pin : pin, stamp_ms);
        stamp_ms = stamp_ms + $urandom_range(0, cls_cfg.debounce_ms / 2 + 2);
      end
    end
    n = $urandom_range(2, 8);
    t0 = stamp_ms;
    for (int i = 1; i <= n; i++) add_scan(pin, t0 + (dur * i) / n);
    stamp_ms = t0 + dur;
  endtask

  task automatic add_gesture();
    int d;
    int w;
    int lp;
    logic b;
    d = int'(cls_cfg.debounce_ms);
    w = window_ms(cls_cfg);
    lp = hold_ms(cls_cfg);
    b = ($urandom_range(0, 2) == 0);
    case ($urandom_range(0, 9))
      0, 1: begin
        hold_level(1'b1, d + 1 + $urandom_range(0, 300), b);
        hold_level(1'b0, w + $urandom_range(0, 400) - 100, b);
      end
      2, 3: begin
        hold_level(1'b1, d + 1 + $urandom_range(0, 100), b);
        hold_level(1'b0, d + $urandom_range(0, w / 2), b);
        hold_level(1'b1, d + 1 + $urandom_range(0, 100), b);
        hold_level(1'b0, d + $urandom_range(0, w), b);
      end
      4: begin
        hold_level(1'b1, lp - 300 + $urandom_range(0, 3000), b);
        hold_level(1'b0, $urandom_range(0, w), b);
      end
      5: begin
        hold_level(1'b1, $urandom_range(0, d), b);
        hold_level(1'b0, $urandom_range(0, 2 * w), b);
      end
      6: hold_level(1'b1, $urandom_range(0, 2000), b);
      7: repeat ($urandom_range(1, 4)) add_scan(1'($urandom_range(0, 1)), $urandom());
      default: hold_level(1'($urandom_range(0, 1)), $urandom_range(0, 1500), b);
    endcase
  endtask

  // register write; bits above the field width get junk
  task automatic reg_write(input cfg_addr_t addr, input cfg_data_t val);
    cfg_data_t mask;
    logic hit;
    case (addr)
      bcc_pkg::REG_DEBOUNCE: mask = 8'hFF;
      bcc_pkg::REG_DC_LEVEL: mask = 8'h0F;
      bcc_pkg::REG_LP_LEVEL: mask = 8'h07;
      default:               mask = 8'h01;
    endcase
    val = (val & mask) | (cfg_data_t'($urandom_range(0, 255)) & ~mask);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wr_data <= val;
    hit = 1'b1;
    case (addr)
      bcc_pkg::REG_DEBOUNCE:    cls_cfg.debounce_ms = val;
      bcc_pkg::REG_DC_LEVEL:    cls_cfg.dc_window_sel = val[3:0];
      bcc_pkg::REG_LP_LEVEL:    cls_cfg.lp_time_sel = val[2:0];
      bcc_pkg::REG_ACTIVE_HIGH: cls_cfg.active_high = val[0];
      bcc_pkg::REG_PAUSE:       cls_cfg.pause_enable = val[0];
      default:                  hit = 1'b0;
    endcase
    if (hit) clear_clicks();
  endtask

  task automatic write_all(input int db, input int dc, input int lp, input int ah, input int pz);
    reg_write(bcc_pkg::REG_DEBOUNCE, cfg_data_t'(db));
    reg_write(bcc_pkg::REG_DC_LEVEL, cfg_data_t'(dc));
    reg_write(bcc_pkg::REG_LP_LEVEL, cfg_data_t'(lp));
    reg_write(bcc_pkg::REG_ACTIVE_HIGH, cfg_data_t'(ah));
    reg_write(bcc_pkg::REG_PAUSE, cfg_data_t'(pz));
  endtask

  function automatic int pick_val(input int max);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return max;
      default: return $urandom_range(0, max);
    endcase
  endfunction

  task automatic setup_phase(input int p);
    case (p)
      0: write_all(0, 0, 0, 1, 0);
      1: write_all(255, 15, 7, 0, 0);
      2: write_all(20, 9, 3, 1, 1);
      3: write_all(5, 10, 7, 1, 0);
      default: begin
        if ($urandom_range(0, 1))
          reg_write(bcc_pkg::REG_DEBOUNCE, cfg_data_t'(pick_val(255)));
        if ($urandom_range(0, 1))
          reg_write(bcc_pkg::REG_DC_LEVEL, cfg_data_t'(pick_val(15)));
        if ($urandom_range(0, 1))
          reg_write(bcc_pkg::REG_LP_LEVEL, cfg_data_t'(pick_val(7)));
        if ($urandom_range(0, 1))
          reg_write(bcc_pkg::REG_ACTIVE_HIGH, cfg_data_t'($urandom_range(0, 1)));
        reg_write(bcc_pkg::REG_PAUSE, cfg_data_t'($urandom_range(0, 7) == 0));
      end
    endcase
    if (p == 1 || $urandom_range(0, 3) == 0)
      reg_write(cfg_addr_t'($urandom_range(int'(bcc_pkg::REG_PAUSE) + 1, int'(ADDR_MAX))),
                cfg_data_t'($urandom_range(0, 255)));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_scans.size() != 0 || in_tvalid || want_events.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int target;
    cls_cfg = bcc_pkg::CFG_RESET;
    flt_level = 1'b0;
    settle_t0 = '0;
    prev_raw = 2'd3;
    clear_clicks();
    fail_count = 0;
    total_items = 0;
    phase_items = 0;
    gap_left = 0;
    stall_left = 0;
    snd_idle_on = 1'b1;
    rcv_idle_on = 1'b1;
    stamp_ms = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, pressed when pin low
    @(negedge clk);
    add_scan(1'b1, 32'd0);
    add_scan(1'b0, 32'd10);
    add_scan(1'b0, 32'd30);
    add_scan(1'b1, 32'd100);
    add_scan(1'b1, 32'd120);
    add_scan(1'b1, 32'd330);
    add_scan(1'b0, 32'd400);
    add_scan(1'b0, 32'd420);
    add_scan(1'b1, 32'd500);
    add_scan(1'b1, 32'd520);
    add_scan(1'b0, 32'd560);
    add_scan(1'b0, 32'd580);
    add_scan(1'b1, 32'd640);
    add_scan(1'b1, 32'd660);
    // long press across the timestamp wrap, then a release that is not a click
    add_scan(1'b0, 32'hFFFF_F000);
    add_scan(1'b0, 32'hFFFF_F020);
    add_scan(1'b0, 32'hFFFF_FFFF);
    add_scan(1'b1, 32'h0000_0010);
    add_scan(1'b1, 32'h0000_0024);
    // press exactly as long as the debounce time is too short to count
    add_scan(1'b0, 32'd100);
    add_scan(1'b0, 32'd120);
    add_scan(1'b1, 32'd120);
    add_scan(1'b1, 32'd140);
    add_scan(1'b1, 32'd400);
    stamp_ms = 32'd1000;

    for (int p = 0; total_items < ITEM_GOAL; p++) begin
      wait_idle();
      setup_phase(p);
      @(negedge clk);
      case ($urandom_range(0, 3))
        0: stamp_ms = $urandom();
        1: stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        default: ;
      endcase
      snd_idle_on = ($urandom_range(0, 2) != 0);
      rcv_idle_on = ($urandom_range(0, 2) != 0);
      target = cls_cfg.pause_enable ? 20 : $urandom_range(60, 150);
      phase_items = 0;
      while (phase_items < target) add_gesture();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
